>>> rtl/sbs_pkg.sv
`default_nettype none

package sbs_pkg;

  localparam int PIXEL_W = 17;
  localparam int SLOT_W = 5;
  localparam int COLOR_W = 8;
  localparam int ROLL_W = 4;
  localparam int COUNT_W = 5;
  localparam int THRESHOLD_W = 18;
  localparam int CFG_INDEX_W = 1;

  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 18'd800;
  localparam logic [COUNT_W-1:0] MIN_MATCHES_RESET = 5'd1;

  typedef enum logic {
    ACT_CLASSIFY = 1'b0,
    ACT_LOAD     = 1'b1
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MATCH_THRESHOLD = 1'b0,
    REG_MIN_MATCHES     = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    action_t             action;
    logic [PIXEL_W-1:0]  pixel;
    logic [SLOT_W-1:0]   sample_slot;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
    logic [ROLL_W-1:0]   update_roll;
  } item_t;

  typedef struct packed {
    logic                foreground;
    logic [COUNT_W-1:0]  match_count;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/sbs_ram.sv
`default_nettype none

module sbs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/sample_background_subtraction_unit.sv
// an accepted beat passes through stages s1, s2 and s3 before its result reaches the output register
// throughput: one beat per cycle unless the skid is full; a classify beat whose pixel
//   may still be written by a beat in the three pipeline stages waits for that write
// the per-slot sample memories are read once per beat, one pixel row per read
// reset (synchronous, rst high) empties the pipeline and output stages and
//   restores the thresholds; sample memory is not cleared and holds junk until loaded
`default_nettype none

module sample_background_subtraction_unit #(
  parameter int PIXELS = 76800,
  parameter int SAMPLES = 20
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  item_valid,
  output logic                                       item_stall,
  input  wire sbs_pkg::item_t                        item,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output sbs_pkg::result_t                           result,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [sbs_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [sbs_pkg::THRESHOLD_W-1:0]       cfg_data
);

  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int CW = $clog2(SAMPLES + 1);

  typedef struct packed {
    logic                             load;
    logic [sbs_pkg::PIXEL_W-1:0]      pixel;
    logic [sbs_pkg::SLOT_W-1:0]       slot;
    logic [3*sbs_pkg::COLOR_W-1:0]    color;
    logic                             in_range;
    logic                             may_write;
  } stage_t;

  logic [sbs_pkg::THRESHOLD_W-1:0] threshold;
  logic [sbs_pkg::COUNT_W-1:0]     min_matches;

  logic   adv;
  logic   accept;
  logic   hazard;
  logic   is_load;
  stage_t entry;

  logic   s1_valid, s2_valid, s3_valid;
  stage_t s1, s2, s3;

  logic [SAMPLES-1:0][23:0]          rd_row;
  logic [SAMPLES-1:0][2:0][15:0]     sq;
  logic [SAMPLES-1:0][2:0][15:0]     s2_sq;
  logic [SAMPLES-1:0]                match;
  logic [SAMPLES-1:0]                s3_match;

  logic [AW+sbs_pkg::PIXEL_W-1:0]    rd_ext, wr_ext;
  logic [AW-1:0]                     raddr, waddr;

  logic [CW-1:0]                     count;
  logic [CW+sbs_pkg::COUNT_W-1:0]    count_ext;
  logic                              background;
  logic                              wr_en;
  logic                              res_v;
  sbs_pkg::result_t                  res;

  logic                              skid_valid;
  sbs_pkg::result_t                  skid;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= sbs_pkg::THRESHOLD_RESET;
      min_matches <= sbs_pkg::MIN_MATCHES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (sbs_pkg::cfg_reg_t'(cfg_index))
        sbs_pkg::REG_MATCH_THRESHOLD: threshold <= cfg_data;
        sbs_pkg::REG_MIN_MATCHES:     min_matches <= cfg_data[sbs_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // entry and read-after-write interlock
  assign adv = !skid_valid;
  assign is_load = (item.action == sbs_pkg::ACT_LOAD);

  always_comb begin
    entry.load = is_load;
    entry.pixel = item.pixel;
    entry.slot = item.sample_slot;
    entry.color = {item.red, item.green, item.blue};
    entry.in_range = {15'd0, item.pixel} < 32'(PIXELS);
    entry.may_write = entry.in_range && ({27'd0, item.sample_slot} < 32'(SAMPLES)) &&
                      (is_load || item.update_roll == '0);
  end

  assign hazard = !is_load &&
                  ((s1_valid && s1.may_write && s1.pixel == item.pixel) ||
                   (s2_valid && s2.may_write && s2.pixel == item.pixel) ||
                   (s3_valid && s3.may_write && s3.pixel == item.pixel));

  assign item_stall = skid_valid || hazard;
  assign accept = item_valid && !item_stall;

  assign rd_ext = {{AW{1'b0}}, item.pixel};
  assign raddr = rd_ext[AW-1:0];
  assign wr_ext = {{AW{1'b0}}, s3.pixel};
  assign waddr = wr_ext[AW-1:0];

  // one memory per sample slot, all read at the same pixel
  for (genvar k = 0; k < SAMPLES; k++) begin : g_slot
    logic we;
    assign we = wr_en && ({27'd0, s3.slot} == 32'(k));

    sbs_ram #(
      .WIDTH(24),
      .DEPTH(PIXELS)
    ) u_ram (
      .clk  (clk),
      .we   (we),
      .waddr(waddr),
      .wdata(s3.color),
      .re   (accept),
      .raddr(raddr),
      .rdata(rd_row[k])
    );

    for (genvar c = 0; c < 3; c++) begin : g_chan
      logic [7:0] a, b, d;
      always_comb begin
        a = rd_row[k][23-8*c -: 8];
        b = s1.color[23-8*c -: 8];
        d = (a > b) ? (a - b) : (b - a);
        sq[k][c] = {8'd0, d} * {8'd0, d};
      end
    end

    logic [17:0] sq_sum;
    assign sq_sum = {2'b00, s2_sq[k][0]} + {2'b00, s2_sq[k][1]} + {2'b00, s2_sq[k][2]};
    assign match[k] = (sq_sum <= threshold);
  end

  // pipeline stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= entry;
      s2 <= s1;
      s2_sq <= sq;
      s3 <= s2;
      s3_match <= match;
    end
  end

  // decision and model update
  assign count = CW'($countones(s3_match));
  assign count_ext = {{sbs_pkg::COUNT_W{1'b0}}, count};
  assign background = s3.in_range && (32'(count) >= 32'(min_matches));
  assign wr_en = s3_valid && adv && s3.may_write && (s3.load || background);
  assign res_v = s3_valid && adv && !s3.load;

  always_comb begin
    res.foreground = !background;
    res.match_count = s3.in_range ? count_ext[sbs_pkg::COUNT_W-1:0] : '0;
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (result_valid && result_stall) begin
      if (res_v) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      result_valid <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      result_valid <= res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid && result_stall) begin
      if (res_v) begin
        skid <= res;
      end
    end else if (skid_valid) begin
      result <= skid;
    end else if (res_v) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sbs_checker.sv
`default_nettype none

module sbs_checker #(
  parameter int SAMPLES = 20
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_stall,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire sbs_pkg::result_t result
);

  // pipeline and output stages come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("not empty after reset");

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  // count never exceeds the samples of one pixel
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (SAMPLES >= 32) || (32'(result.match_count) <= SAMPLES))
    else $error("match count above sample count");

  // a result beat never carries unknown bits
  a_result_known: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !$isunknown(result))
    else $error("result beat with unknown bits");

endmodule

bind sample_background_subtraction_unit sbs_checker #(
  .SAMPLES(SAMPLES)
) u_sbs_checker (
  .clk         (clk),
  .rst         (rst),
  .item_stall  (item_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);

`default_nettype wire
